// ----- rtl/keyboard_report_to_gamepad_macros.svh -----
// Assertion macros shared by the keyboard-to-gamepad RTL.
// Each macro expects clk and arst_n in scope of the including module.
`ifndef KEYBOARD_REPORT_TO_GAMEPAD_MACROS_SVH
`define KEYBOARD_REPORT_TO_GAMEPAD_MACROS_SVH

// Same-cycle implication, checked outside reset
`define KBGP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define KBGP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/kbgp_pkg.sv -----
// Shared types, constants and key map for the keyboard-to-gamepad block.
// No dependencies; the top level, kbgp_lane and kbgp_merge import this package.
`timescale 1ns / 1ps
`default_nettype none

package kbgp_pkg;

	localparam int MAP_ENTRIES_DEF     = 32;
	localparam int KEYS_PER_REPORT_DEF = 6;
	localparam int KEYS_MAX            = 6;

	localparam logic [3:0]  HAT_NEUTRAL     = 4'h8;
	localparam logic [7:0]  AXIS_CENTER     = 8'd128;
	localparam logic [7:0]  AXIS_MAX        = 8'd255;
	localparam logic [15:0] KEEPALIVE_RESET = 16'd100;
	localparam logic [15:0] ELAPSED_SAT     = 16'hFFFF;

	// direction bits inside a map entry value
	localparam int DIR_UP_BIT    = 0;
	localparam int DIR_DOWN_BIT  = 1;
	localparam int DIR_LEFT_BIT  = 2;
	localparam int DIR_RIGHT_BIT = 3;

	typedef enum logic [1:0] {
		CMD_REPORT  = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_MOUNT   = 2'd2,
		CMD_UNMOUNT = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_BUTTON = 3'd1,
		KIND_DPAD   = 3'd2,
		KIND_LSTICK = 3'd3,
		KIND_RSTICK = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0]  code;
		kind_t       kind;
		logic [15:0] value;
	} map_entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
	} lane_hit_t;

	typedef struct packed {
		logic [15:0] buttons;
		logic [3:0]  hat;
		logic [7:0]  left_x;
		logic [7:0]  left_y;
		logic [7:0]  right_x;
		logic [7:0]  right_y;
	} pad_frame_t;

	typedef struct packed {
		pad_frame_t frame;
		logic       changed;
	} send_entry_t;

	localparam pad_frame_t FRAME_IDLE = '{
		buttons: 16'h0000, hat: HAT_NEUTRAL,
		left_x: AXIS_CENTER, left_y: AXIS_CENTER,
		right_x: AXIS_CENTER, right_y: AXIS_CENTER
	};

	// Fixed key map of standard HID usage codes; slots past the list are empty.
	function automatic map_entry_t map_rom(input logic [5:0] idx);
		map_entry_t e;
		e = '{code: 8'h00, kind: KIND_NONE, value: 16'h0000};
		case (idx)
			6'd0:  e = '{code: 8'h1A, kind: KIND_DPAD,   value: 16'h0001};
			6'd1:  e = '{code: 8'h16, kind: KIND_DPAD,   value: 16'h0002};
			6'd2:  e = '{code: 8'h04, kind: KIND_DPAD,   value: 16'h0004};
			6'd3:  e = '{code: 8'h07, kind: KIND_DPAD,   value: 16'h0008};
			6'd4:  e = '{code: 8'h0C, kind: KIND_BUTTON, value: 16'h0008};
			6'd5:  e = '{code: 8'h0E, kind: KIND_BUTTON, value: 16'h0001};
			6'd6:  e = '{code: 8'h0D, kind: KIND_BUTTON, value: 16'h0004};
			6'd7:  e = '{code: 8'h0F, kind: KIND_BUTTON, value: 16'h0002};
			6'd8:  e = '{code: 8'h14, kind: KIND_BUTTON, value: 16'h0010};
			6'd9:  e = '{code: 8'h08, kind: KIND_BUTTON, value: 16'h0020};
			6'd10: e = '{code: 8'h15, kind: KIND_BUTTON, value: 16'h0040};
			6'd11: e = '{code: 8'h09, kind: KIND_BUTTON, value: 16'h0080};
			6'd12: e = '{code: 8'h0A, kind: KIND_BUTTON, value: 16'h0010};
			6'd13: e = '{code: 8'h17, kind: KIND_BUTTON, value: 16'h0020};
			6'd14: e = '{code: 8'h1E, kind: KIND_BUTTON, value: 16'h0100};
			6'd15: e = '{code: 8'h1F, kind: KIND_BUTTON, value: 16'h0200};
			6'd16: e = '{code: 8'h20, kind: KIND_BUTTON, value: 16'h0400};
			6'd17: e = '{code: 8'h21, kind: KIND_BUTTON, value: 16'h0800};
			6'd18: e = '{code: 8'h0B, kind: KIND_BUTTON, value: 16'h1000};
			6'd19: e = '{code: 8'h06, kind: KIND_BUTTON, value: 16'h2000};
			6'd20: e = '{code: 8'h52, kind: KIND_DPAD,   value: 16'h0001};
			6'd21: e = '{code: 8'h51, kind: KIND_DPAD,   value: 16'h0002};
			6'd22: e = '{code: 8'h50, kind: KIND_DPAD,   value: 16'h0004};
			6'd23: e = '{code: 8'h4F, kind: KIND_DPAD,   value: 16'h0008};
			6'd24: e = '{code: 8'h60, kind: KIND_LSTICK, value: 16'h0001};
			6'd25: e = '{code: 8'h5D, kind: KIND_LSTICK, value: 16'h0002};
			6'd26: e = '{code: 8'h5C, kind: KIND_LSTICK, value: 16'h0004};
			6'd27: e = '{code: 8'h5E, kind: KIND_LSTICK, value: 16'h0008};
			6'd28: e = '{code: 8'h18, kind: KIND_RSTICK, value: 16'h0001};
			6'd29: e = '{code: 8'h10, kind: KIND_RSTICK, value: 16'h0002};
			6'd30: e = '{code: 8'h11, kind: KIND_RSTICK, value: 16'h0004};
			6'd31: e = '{code: 8'h36, kind: KIND_RSTICK, value: 16'h0008};
			default: e = '{code: 8'h00, kind: KIND_NONE, value: 16'h0000};
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/kbgp_evt_if.sv -----
// Event channel: command plus six HID key codes, valid/ready handshake.
// Standalone; used by the top level input port.
`timescale 1ns / 1ps
`default_nettype none

interface kbgp_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] key0;
	logic [7:0] key1;
	logic [7:0] key2;
	logic [7:0] key3;
	logic [7:0] key4;
	logic [7:0] key5;

	modport source (output valid, cmd, key0, key1, key2, key3, key4, key5, input ready);
	modport sink   (input valid, cmd, key0, key1, key2, key3, key4, key5, output ready);
endinterface

`default_nettype wire

// ----- rtl/kbgp_pad_if.sv -----
// Gamepad frame channel, valid/ready handshake.
// Standalone; used by the top level output port.
`timescale 1ns / 1ps
`default_nettype none

interface kbgp_pad_if;
	logic        valid;
	logic        ready;
	logic [15:0] buttons;
	logic [3:0]  hat;
	logic [7:0]  left_x;
	logic [7:0]  left_y;
	logic [7:0]  right_x;
	logic [7:0]  right_y;
	logic        frame_changed;

	modport source (output valid, buttons, hat, left_x, left_y, right_x, right_y,
		frame_changed, input ready);
	modport sink   (input valid, buttons, hat, left_x, left_y, right_x, right_y,
		frame_changed, output ready);
endinterface

`default_nettype wire

// ----- rtl/keyboard_report_to_gamepad.sv -----
// Top level: key lanes, merge register, frame state and send decision, output queue.
// Depends on kbgp_pkg, kbgp_evt_if, kbgp_pad_if, kbgp_lane, kbgp_merge and the macro header.
//
//   port      dir  handshake        carries
//   evt       in   valid/ready      cmd, key0..key5
//   pad       out  valid/ready      buttons, hat, sticks, frame_changed
//   cfg       in   cfg_wr_en only   keepalive interval in ms
//
// One event per cycle while evt.ready is high. Stage 1 registers the merged lane decode;
// stage 2 updates the frame state and, while mounted, pushes a frame into a two-entry
// queue when it changed or the keepalive interval is reached. pad.valid comes from the
// registered queue count, so a frame reaches it through the stage 1 register and the queue.
// evt.ready drops only when the queue cannot take the event in flight plus one more.
// Reset is asynchronous; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "keyboard_report_to_gamepad_macros.svh"

module keyboard_report_to_gamepad #(
	parameter int MAP_ENTRIES     = kbgp_pkg::MAP_ENTRIES_DEF,
	parameter int KEYS_PER_REPORT = kbgp_pkg::KEYS_PER_REPORT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	kbgp_evt_if.sink    evt,
	kbgp_pad_if.source  pad,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import kbgp_pkg::*;

	logic [7:0]  keys [KEYS_MAX];
	lane_hit_t   hits [KEYS_PER_REPORT];
	pad_frame_t  frame_w;

	logic        evt_xfer;
	logic        valid_s1;
	cmd_t        cmd_s1;
	pad_frame_t  frame_s1;

	pad_frame_t  cur_q;
	pad_frame_t  last_q;
	logic [15:0] elapsed_q;
	logic        present_q;
	logic [15:0] keepalive_q;

	pad_frame_t  nxt_cur;
	logic        nxt_present;
	logic [15:0] nxt_elapsed;
	logic        changed_w;
	logic        push_w;
	logic        deq_w;
	logic [1:0]  occ_w;

	send_entry_t fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign keys[0] = evt.key0;
	assign keys[1] = evt.key1;
	assign keys[2] = evt.key2;
	assign keys[3] = evt.key3;
	assign keys[4] = evt.key4;
	assign keys[5] = evt.key5;

	for (genvar g = 0; g < KEYS_PER_REPORT; g++) begin : g_lane
		kbgp_lane #(.MAP_ENTRIES(MAP_ENTRIES)) u_lane (
			.key (keys[g]),
			.hit (hits[g])
		);
	end

	kbgp_merge #(.KEYS_PER_REPORT(KEYS_PER_REPORT)) u_merge (
		.hits  (hits),
		.frame (frame_w)
	);

	// queue occupancy once this cycle settles, counting the event in stage 1
	assign deq_w     = pad.valid && pad.ready;
	assign occ_w     = cnt_q - 2'(deq_w) + 2'(valid_s1);
	assign evt.ready = occ_w < 2'd2;
	assign evt_xfer  = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= evt_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_xfer) begin
			cmd_s1   <= cmd_t'(evt.cmd);
			frame_s1 <= frame_w;
		end
	end

	always_comb begin
		nxt_cur     = cur_q;
		nxt_present = present_q;
		nxt_elapsed = elapsed_q;
		case (cmd_s1)
			CMD_REPORT: begin
				if (present_q) nxt_cur = frame_s1;
			end
			CMD_TICK: begin
				if (elapsed_q != ELAPSED_SAT) nxt_elapsed = elapsed_q + 16'd1;
			end
			CMD_MOUNT: begin
				nxt_present = 1'b1;
			end
			CMD_UNMOUNT: begin
				// drop buttons and hat; sticks hold
				if (present_q) begin
					nxt_present     = 1'b0;
					nxt_cur.buttons = 16'h0000;
					nxt_cur.hat     = HAT_NEUTRAL;
				end
			end
			default: ;
		endcase
	end

	assign changed_w = nxt_cur != last_q;
	assign push_w    = valid_s1 && nxt_present && (changed_w || nxt_elapsed >= keepalive_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= FRAME_IDLE;
			last_q      <= FRAME_IDLE;
			elapsed_q   <= ELAPSED_SAT;
			present_q   <= 1'b0;
			keepalive_q <= KEEPALIVE_RESET;
			wr_ptr_q    <= 1'b0;
			rd_ptr_q    <= 1'b0;
			cnt_q       <= 2'd0;
		end else begin
			if (cfg_wr_en) keepalive_q <= cfg_wr_data;
			if (valid_s1) begin
				cur_q     <= nxt_cur;
				present_q <= nxt_present;
				elapsed_q <= push_w ? 16'd0 : nxt_elapsed;
				if (push_w) last_q <= nxt_cur;
			end
			if (push_w) wr_ptr_q <= !wr_ptr_q;
			if (deq_w)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push_w) - 2'(deq_w);
		end
	end

	always_ff @(posedge clk) begin
		if (push_w) fifo_q[wr_ptr_q] <= '{frame: nxt_cur, changed: changed_w};
	end

	assign pad.valid         = cnt_q != 2'd0;
	assign pad.buttons       = fifo_q[rd_ptr_q].frame.buttons;
	assign pad.hat           = fifo_q[rd_ptr_q].frame.hat;
	assign pad.left_x        = fifo_q[rd_ptr_q].frame.left_x;
	assign pad.left_y        = fifo_q[rd_ptr_q].frame.left_y;
	assign pad.right_x       = fifo_q[rd_ptr_q].frame.right_x;
	assign pad.right_y       = fifo_q[rd_ptr_q].frame.right_y;
	assign pad.frame_changed = fifo_q[rd_ptr_q].changed;

	`KBGP_ASSERT_NOW(a_no_overflow, push_w, (cnt_q != 2'd2) || deq_w, "send queue overflow")
	`KBGP_ASSERT_NEXT(a_send_clears_elapsed, push_w, elapsed_q == 16'd0, "elapsed not cleared on send")
	`KBGP_ASSERT_NOW(a_absent_idle, !present_q, (cur_q.buttons == 16'h0000) && (cur_q.hat == HAT_NEUTRAL), "buttons or hat held while unmounted")
	`KBGP_ASSERT_NEXT(a_last_matches_sent, push_w, last_q == cur_q, "last sent frame out of step")

endmodule

`default_nettype wire

// ----- rtl/kbgp_lane.sv -----
// One key lane: matches a single HID code against the key map, first hit wins.
// Depends on kbgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kbgp_lane #(
	parameter int MAP_ENTRIES = kbgp_pkg::MAP_ENTRIES_DEF
) (
	input  logic [7:0]          key,
	output kbgp_pkg::lane_hit_t hit
);
	import kbgp_pkg::*;

	logic [MAP_ENTRIES-1:0] match;

	always_comb begin
		for (int j = 0; j < MAP_ENTRIES; j++) begin
			match[j] = (key != 8'h00) && (map_rom(6'(j)).kind != KIND_NONE) &&
				(map_rom(6'(j)).code == key);
		end
	end

	// walk from the back so the lowest matching entry is left standing
	always_comb begin
		hit = '{kind: KIND_NONE, value: 16'h0000};
		for (int j = MAP_ENTRIES - 1; j >= 0; j--) begin
			if (match[j]) begin
				hit = '{kind: map_rom(6'(j)).kind, value: map_rom(6'(j)).value};
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/kbgp_merge.sv -----
// Merge stage: ORs the lane hits and builds buttons, hat and stick axes.
// Depends on kbgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kbgp_merge #(
	parameter int KEYS_PER_REPORT = kbgp_pkg::KEYS_PER_REPORT_DEF
) (
	input  kbgp_pkg::lane_hit_t  hits [KEYS_PER_REPORT],
	output kbgp_pkg::pad_frame_t frame
);
	import kbgp_pkg::*;

	logic [15:0] btn;
	logic [3:0]  dpad;
	logic [3:0]  lstick;
	logic [3:0]  rstick;

	function automatic logic [3:0] combine_hat(input logic [3:0] d);
		logic up, dn, lf, rt;
		up = d[DIR_UP_BIT];
		dn = d[DIR_DOWN_BIT];
		lf = d[DIR_LEFT_BIT];
		rt = d[DIR_RIGHT_BIT];
		if (up && rt)      return 4'd1;
		else if (up && lf) return 4'd7;
		else if (dn && rt) return 4'd3;
		else if (dn && lf) return 4'd5;
		else if (up)       return 4'd0;
		else if (dn)       return 4'd4;
		else if (lf)       return 4'd6;
		else if (rt)       return 4'd2;
		else               return HAT_NEUTRAL;
	endfunction

	// low direction (up/left) wins over high (down/right)
	function automatic logic [7:0] axis_of(input logic low_dir, input logic high_dir);
		if (low_dir)       return 8'd0;
		else if (high_dir) return AXIS_MAX;
		else               return AXIS_CENTER;
	endfunction

	always_comb begin
		btn    = '0;
		dpad   = '0;
		lstick = '0;
		rstick = '0;
		for (int i = 0; i < KEYS_PER_REPORT; i++) begin
			case (hits[i].kind)
				KIND_BUTTON: btn    = btn | hits[i].value;
				KIND_DPAD:   dpad   = dpad | hits[i].value[3:0];
				KIND_LSTICK: lstick = lstick | hits[i].value[3:0];
				KIND_RSTICK: rstick = rstick | hits[i].value[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		frame.buttons = btn;
		frame.hat     = combine_hat(dpad);
		frame.left_x  = axis_of(lstick[DIR_LEFT_BIT], lstick[DIR_RIGHT_BIT]);
		frame.left_y  = axis_of(lstick[DIR_UP_BIT], lstick[DIR_DOWN_BIT]);
		frame.right_x = axis_of(rstick[DIR_LEFT_BIT], rstick[DIR_RIGHT_BIT]);
		frame.right_y = axis_of(rstick[DIR_UP_BIT], rstick[DIR_DOWN_BIT]);
	end

endmodule

`default_nettype wire
